>>> design/shvm_pkg.sv
// shared types, constants and helper functions of the vertex merge block
`timescale 1ns / 1ps
package shvm_pkg;

   localparam logic [63:0] HASH_LABEL_MUL = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] HASH_MIX_MUL   = 64'hBF58_476D_1CE4_E5B9;

   localparam logic [30:0] EXACT_GRID  = 31'd2048;
   localparam logic [30:0] TOL_RESET   = 31'd65536;
   localparam logic signed [33:0] CELL_HALF = 34'sd1048576;
   localparam logic signed [33:0] CELL_LO   = -34'sd1048575;
   localparam logic signed [33:0] CELL_HI   = 34'sd1048574;

   localparam logic [2:0] ST_MATCHED     = 3'd0;
   localparam logic [2:0] ST_INSERTED    = 3'd1;
   localparam logic [2:0] ST_STORE_FULL  = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
   localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   localparam logic [1:0] PR_ABSENT = 2'd0;
   localparam logic [1:0] PR_FOUND  = 2'd1;
   localparam logic [1:0] PR_FULL   = 2'd2;

   localparam logic [1:0] OFS_NEG  = 2'b11;
   localparam logic [1:0] OFS_ZERO = 2'b00;
   localparam logic [1:0] OFS_POS  = 2'b01;

   typedef struct packed {
      logic        func;
      logic [31:0] coord_x;
      logic [31:0] coord_y;
      logic [31:0] coord_z;
      logic [31:0] vertex_label;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [11:0] vertex_index;
      logic [2:0]  status;
   } result_type;

   function automatic logic [62:0] pack_cell(input logic signed [33:0] cx,
                                             input logic signed [33:0] cy,
                                             input logic signed [33:0] cz);
      logic [33:0] px;
      logic [33:0] py;
      logic [33:0] pz;
      px = cx + CELL_HALF;
      py = cy + CELL_HALF;
      pz = cz + CELL_HALF;
      return {px[20:0], py[20:0], pz[20:0]};
   endfunction

   function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(a) - 33'(b);
      return d[32] ? 33'(-d) : 33'(d);
   endfunction

endpackage

>>> design/shvm_div.sv
// iterative signed floor divider, one quotient bit per cycle
`timescale 1ns / 1ps
module shvm_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic [30:0]        den,
   output logic               done,
   output logic signed [33:0] quo
);
   import shvm_pkg::*;

   logic [31:0] rem_ff;
   logic [31:0] rem_in;
   logic [32:0] q_ff;
   logic [32:0] q_in;
   logic [30:0] den_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic        neg_ff;
   logic        done_ff;
   logic [32:0] trial;
   logic        ge;
   logic signed [32:0] num_ext;

   assign num_ext = 33'(num);
   assign trial   = {rem_ff, q_ff[32]};
   assign ge      = trial >= {2'b00, den_ff};
   assign rem_in  = ge ? 32'(trial - {2'b00, den_ff}) : trial[31:0];
   assign q_in    = {q_ff[31:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd33;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         q_ff   <= num[31] ? 33'(-num_ext) : 33'(num_ext);
         den_ff <= den;
         neg_ff <= num[31];
      end else if (run_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? (-34'(q_ff) - 34'(rem_ff != '0)) : 34'(q_ff);

endmodule

>>> design/shvm_core.sv
// sequencer with the vertex store, cell table and bucket memories
`timescale 1ns / 1ps
module shvm_core #(
   parameter int MAX_VERTICES = 4096,
   parameter int CELL_SLOTS   = 1024,
   parameter int BUCKET_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  shvm_pkg::item_type   item,
   input  logic [30:0]          tol,
   input  logic                 out_free,
   output logic                 ready,
   output shvm_pkg::result_type result
);
   import shvm_pkg::*;

   localparam int IW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int SAW = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
   localparam int MD  = CELL_SLOTS * BUCKET_DEPTH;
   localparam int MAW = (MD > 1) ? $clog2(MD) : 1;
   localparam int FW  = $clog2(BUCKET_DEPTH + 1);
   localparam int SLW = 1 + FW + 32 + 63;

   localparam logic [4:0] S_SWEEP = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_LK1   = 5'd2;
   localparam logic [4:0] S_LK2   = 5'd3;
   localparam logic [4:0] S_LK3   = 5'd4;
   localparam logic [4:0] S_TT    = 5'd5;
   localparam logic [4:0] S_DIVW  = 5'd6;
   localparam logic [4:0] S_RANGE = 5'd7;
   localparam logic [4:0] S_H0    = 5'd8;
   localparam logic [4:0] S_H1    = 5'd9;
   localparam logic [4:0] S_H2    = 5'd10;
   localparam logic [4:0] S_H3    = 5'd11;
   localparam logic [4:0] S_H4    = 5'd12;
   localparam logic [4:0] S_MOD   = 5'd13;
   localparam logic [4:0] S_P1    = 5'd14;
   localparam logic [4:0] S_P2    = 5'd15;
   localparam logic [4:0] S_M1    = 5'd16;
   localparam logic [4:0] S_M2    = 5'd17;
   localparam logic [4:0] S_M3    = 5'd18;
   localparam logic [4:0] S_D1    = 5'd19;
   localparam logic [4:0] S_D2    = 5'd20;
   localparam logic [4:0] S_D3    = 5'd21;
   localparam logic [4:0] S_D4    = 5'd22;
   localparam logic [4:0] S_NEXT  = 5'd23;
   localparam logic [4:0] S_INS   = 5'd24;
   localparam logic [4:0] S_RESP  = 5'd25;

   localparam logic [SAW:0] SLOTS_N = (SAW + 1)'(CELL_SLOTS);

   // memories
   logic [SLW-1:0] slot_mem [CELL_SLOTS];
   logic [IW-1:0]  memb_mem [MD];
   logic [95:0]    vtx_mem  [MAX_VERTICES];
   logic [SLW-1:0] slot_rd_ff;
   logic [IW-1:0]  memb_rd_ff;
   logic [95:0]    vtx_rd_ff;

   logic [4:0]  state_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic [31:0] label_ff;
   logic [30:0] tol_ff;
   logic [63:0] lk_ff, acc_ff, prod_ff, x1_ff, modx_ff;
   logic [61:0] tt_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic [1:0]  ox_ff, oy_ff, oz_ff;
   logic        own_ff;
   logic [62:0] own_key_ff;
   logic [SAW-1:0] modr_ff, slot_ff, pcnt_ff, own_slot_ff, sweep_ff;
   logic [3:0]  mcnt_ff;
   logic [1:0]  own_pr_ff;
   logic [FW-1:0] own_fill_ff, cur_fill_ff, k_ff;
   logic [31:0] dx_ff, dy_ff, dz_ff;
   logic [CW-1:0] count_ff;
   logic        clr_rsp_ff;
   logic [11:0] res_idx_ff;
   logic [2:0]  res_st_ff;

   logic        div_start, div_done_x, div_done_y, div_done_z;
   logic signed [33:0] qx, qy, qz;
   logic [30:0] div_den;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [62:0] key_cur;
   logic [63:0] x0, hv, dsum;
   logic [SAW-1:0] mod_next;
   logic [5:0]  ofs, ofs_n1, ofs_nxt;
   logic [32:0] adx, ady, adz;
   logic        far, exact, ins_ok, slot_hit;
   logic [FW-1:0] fill_old;

   logic [SAW-1:0] slot_addr;
   logic           slot_we;
   logic [SLW-1:0] slot_wd;
   logic [MAW-1:0] memb_addr;
   logic           memb_we;
   logic [IW-1:0]  vtx_addr;
   logic           vtx_we;

   function automatic logic [5:0] lex_next(input logic [5:0] o);
      logic [1:0] a;
      logic [1:0] b;
      logic [1:0] c;
      a = o[5:4];
      b = o[3:2];
      c = o[1:0];
      if (c == OFS_POS) begin
         c = OFS_NEG;
         if (b == OFS_POS) begin
            b = OFS_NEG;
            a = a + 2'd1;
         end else begin
            b = b + 2'd1;
         end
      end else begin
         c = c + 2'd1;
      end
      return {a, b, c};
   endfunction

   function automatic logic [SAW-1:0] mod_step4(input logic [SAW-1:0] r,
                                                input logic [3:0] bits);
      logic [SAW:0] t;
      logic [SAW-1:0] acc;
      acc = r;
      for (int i = 3; i >= 0; i--) begin
         t = {acc, bits[i]};
         if (t >= SLOTS_N) t = t - SLOTS_N;
         acc = t[SAW-1:0];
      end
      return acc;
   endfunction

   // three floor dividers, one per axis
   assign div_start = start && (item.func == FUNC_ADD);
   assign div_den   = (tol == '0) ? EXACT_GRID : tol;

   shvm_div u_div_x (.clock(clock), .reset(reset), .start(div_start),
      .num(item.coord_x), .den(div_den), .done(div_done_x), .quo(qx));
   shvm_div u_div_y (.clock(clock), .reset(reset), .start(div_start),
      .num(item.coord_y), .den(div_den), .done(div_done_y), .quo(qy));
   shvm_div u_div_z (.clock(clock), .reset(reset), .start(div_start),
      .num(item.coord_z), .den(div_den), .done(div_done_z), .quo(qz));

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_LK1: begin
            mul_a = label_ff;
            mul_b = HASH_LABEL_MUL[31:0];
         end
         S_LK2: begin
            mul_a = label_ff;
            mul_b = HASH_LABEL_MUL[63:32];
         end
         S_LK3: begin
            mul_a = {1'b0, tol_ff};
            mul_b = {1'b0, tol_ff};
         end
         S_H1: begin
            mul_a = x1_ff[31:0];
            mul_b = HASH_MIX_MUL[31:0];
         end
         S_H2: begin
            mul_a = x1_ff[63:32];
            mul_b = HASH_MIX_MUL[31:0];
         end
         S_H3: begin
            mul_a = x1_ff[31:0];
            mul_b = HASH_MIX_MUL[63:32];
         end
         S_D1: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         S_D2: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         S_D3: begin
            mul_a = dz_ff;
            mul_b = dz_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
   end

   assign ofs     = {ox_ff, oy_ff, oz_ff};
   assign ofs_n1  = lex_next(ofs);
   assign ofs_nxt = (ofs_n1 == '0) ? lex_next(ofs_n1) : ofs_n1;
   assign key_cur = pack_cell(cx_ff + 34'($signed(ox_ff)), cy_ff + 34'($signed(oy_ff)),
                              cz_ff + 34'($signed(oz_ff)));
   assign x0       = {1'b0, key_cur} ^ lk_ff;
   assign hv       = acc_ff + {prod_ff[31:0], 32'b0};
   assign dsum     = acc_ff + prod_ff;
   assign mod_next = mod_step4(modr_ff, modx_ff[63:60]);

   assign adx   = abs_diff(x_ff, vtx_rd_ff[95:64]);
   assign ady   = abs_diff(y_ff, vtx_rd_ff[63:32]);
   assign adz   = abs_diff(z_ff, vtx_rd_ff[31:0]);
   assign exact = (adx == '0) && (ady == '0) && (adz == '0);
   assign far   = (adx > {2'b00, tol_ff}) || (ady > {2'b00, tol_ff})
                  || (adz > {2'b00, tol_ff});

   assign slot_hit = (slot_rd_ff[94:63] == label_ff) && (slot_rd_ff[62:0] == key_cur);
   assign fill_old = (own_pr_ff == PR_FOUND) ? own_fill_ff : '0;
   assign ins_ok   = (count_ff < CW'(MAX_VERTICES)) && (own_pr_ff != PR_FULL)
                     && !((own_pr_ff == PR_FOUND) && (own_fill_ff == FW'(BUCKET_DEPTH)));

   // memory ports
   always_comb begin
      slot_addr = slot_ff;
      slot_we   = 1'b0;
      slot_wd   = {1'b1, FW'(fill_old + FW'(1)), label_ff, own_key_ff};
      memb_addr = MAW'(32'(slot_ff) * 32'(BUCKET_DEPTH) + 32'(k_ff));
      memb_we   = 1'b0;
      vtx_addr  = memb_rd_ff;
      vtx_we    = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            slot_addr = sweep_ff;
            slot_we   = 1'b1;
            slot_wd   = '0;
         end
         S_INS: begin
            slot_addr = own_slot_ff;
            slot_we   = ins_ok;
            memb_addr = MAW'(32'(own_slot_ff) * 32'(BUCKET_DEPTH) + 32'(fill_old));
            memb_we   = ins_ok;
            vtx_addr  = count_ff[IW-1:0];
            vtx_we    = ins_ok;
         end
         default: begin
            slot_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_addr] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (memb_we) memb_mem[memb_addr] <= count_ff[IW-1:0];
      memb_rd_ff <= memb_mem[memb_addr];
   end

   always_ff @(posedge clock) begin
      if (vtx_we) vtx_mem[vtx_addr] <= {x_ff, y_ff, z_ff};
      vtx_rd_ff <= vtx_mem[vtx_addr];
   end

   // payload captured at item start
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff     <= item.coord_x;
         y_ff     <= item.coord_y;
         z_ff     <= item.coord_z;
         label_ff <= item.vertex_label;
         tol_ff   <= tol;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_SWEEP;
         sweep_ff   <= '0;
         clr_rsp_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         case (state_ff)
            S_SWEEP: begin
               sweep_ff <= sweep_ff + SAW'(1);
               if (sweep_ff == SAW'(CELL_SLOTS - 1)) begin
                  state_ff <= clr_rsp_ff ? S_RESP : S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  if (item.func == FUNC_CLEAR) begin
                     count_ff   <= '0;
                     sweep_ff   <= '0;
                     clr_rsp_ff <= 1'b1;
                     res_idx_ff <= '0;
                     res_st_ff  <= ST_MATCHED;
                     state_ff   <= S_SWEEP;
                  end else begin
                     state_ff <= S_LK1;
                  end
               end
            end
            S_LK1: state_ff <= S_LK2;
            S_LK2: begin
               acc_ff   <= prod_ff;
               state_ff <= S_LK3;
            end
            S_LK3: begin
               lk_ff    <= acc_ff + {prod_ff[31:0], 32'b0};
               state_ff <= S_TT;
            end
            S_TT: begin
               tt_ff    <= prod_ff[61:0];
               state_ff <= S_DIVW;
            end
            S_DIVW: begin
               if (div_done_x && div_done_y && div_done_z) begin
                  cx_ff    <= qx;
                  cy_ff    <= qy;
                  cz_ff    <= qz;
                  state_ff <= S_RANGE;
               end
            end
            S_RANGE: begin
               if ((tol_ff != '0) && ((cx_ff < CELL_LO) || (cx_ff > CELL_HI)
                   || (cy_ff < CELL_LO) || (cy_ff > CELL_HI)
                   || (cz_ff < CELL_LO) || (cz_ff > CELL_HI))) begin
                  res_idx_ff <= '0;
                  res_st_ff  <= ST_OUT_OF_RANGE;
                  state_ff   <= S_RESP;
               end else begin
                  own_ff     <= 1'b1;
                  ox_ff      <= OFS_ZERO;
                  oy_ff      <= OFS_ZERO;
                  oz_ff      <= OFS_ZERO;
                  own_key_ff <= pack_cell(cx_ff, cy_ff, cz_ff);
                  state_ff   <= S_H0;
               end
            end
            S_H0: begin
               x1_ff    <= x0 ^ (x0 >> 29);
               state_ff <= S_H1;
            end
            S_H1: state_ff <= S_H2;
            S_H2: begin
               acc_ff   <= prod_ff;
               state_ff <= S_H3;
            end
            S_H3: begin
               acc_ff   <= hv;
               state_ff <= S_H4;
            end
            S_H4: begin
               modx_ff  <= hv ^ (hv >> 32);
               modr_ff  <= '0;
               mcnt_ff  <= '0;
               state_ff <= S_MOD;
            end
            S_MOD: begin
               modr_ff <= mod_next;
               modx_ff <= {modx_ff[59:0], 4'b0};
               mcnt_ff <= mcnt_ff + 4'd1;
               if (mcnt_ff == 4'd15) begin
                  slot_ff  <= mod_next;
                  pcnt_ff  <= '0;
                  state_ff <= S_P1;
               end
            end
            S_P1: state_ff <= S_P2;
            S_P2: begin
               if (!slot_rd_ff[SLW-1]) begin
                  if (own_ff) begin
                     own_pr_ff   <= PR_ABSENT;
                     own_slot_ff <= slot_ff;
                  end
                  state_ff <= S_NEXT;
               end else if (slot_hit) begin
                  if (own_ff) begin
                     own_pr_ff   <= PR_FOUND;
                     own_slot_ff <= slot_ff;
                     own_fill_ff <= slot_rd_ff[SLW-2 -: FW];
                  end
                  cur_fill_ff <= slot_rd_ff[SLW-2 -: FW];
                  k_ff        <= '0;
                  state_ff    <= (slot_rd_ff[SLW-2 -: FW] == '0) ? S_NEXT : S_M1;
               end else if (pcnt_ff == SAW'(CELL_SLOTS - 1)) begin
                  if (own_ff) own_pr_ff <= PR_FULL;
                  state_ff <= S_NEXT;
               end else begin
                  slot_ff  <= (slot_ff == SAW'(CELL_SLOTS - 1)) ? '0 : slot_ff + SAW'(1);
                  pcnt_ff  <= pcnt_ff + SAW'(1);
                  state_ff <= S_P1;
               end
            end
            S_M1: state_ff <= S_M2;
            S_M2: state_ff <= S_M3;
            S_M3: begin
               if ((tol_ff == '0) ? exact : !far) begin
                  if (tol_ff == '0) begin
                     res_idx_ff <= 12'(memb_rd_ff);
                     res_st_ff  <= ST_MATCHED;
                     state_ff   <= S_RESP;
                  end else begin
                     dx_ff    <= adx[31:0];
                     dy_ff    <= ady[31:0];
                     dz_ff    <= adz[31:0];
                     state_ff <= S_D1;
                  end
               end else begin
                  k_ff     <= k_ff + FW'(1);
                  state_ff <= (k_ff + FW'(1) == cur_fill_ff) ? S_NEXT : S_M1;
               end
            end
            S_D1: state_ff <= S_D2;
            S_D2: begin
               acc_ff   <= prod_ff;
               state_ff <= S_D3;
            end
            S_D3: begin
               acc_ff   <= dsum;
               state_ff <= S_D4;
            end
            S_D4: begin
               if (dsum <= {2'b00, tt_ff}) begin
                  res_idx_ff <= 12'(memb_rd_ff);
                  res_st_ff  <= ST_MATCHED;
                  state_ff   <= S_RESP;
               end else begin
                  k_ff     <= k_ff + FW'(1);
                  state_ff <= (k_ff + FW'(1) == cur_fill_ff) ? S_NEXT : S_M1;
               end
            end
            S_NEXT: begin
               if (own_ff) begin
                  if (tol_ff == '0) begin
                     state_ff <= S_INS;
                  end else begin
                     own_ff   <= 1'b0;
                     ox_ff    <= OFS_NEG;
                     oy_ff    <= OFS_NEG;
                     oz_ff    <= OFS_NEG;
                     state_ff <= S_H0;
                  end
               end else if (ofs == {OFS_POS, OFS_POS, OFS_POS}) begin
                  state_ff <= S_INS;
               end else begin
                  {ox_ff, oy_ff, oz_ff} <= ofs_nxt;
                  state_ff <= S_H0;
               end
            end
            S_INS: begin
               res_idx_ff <= '0;
               if (count_ff >= CW'(MAX_VERTICES)) begin
                  res_st_ff <= ST_STORE_FULL;
               end else if (!ins_ok) begin
                  res_st_ff <= ST_TABLE_FULL;
               end else begin
                  res_idx_ff <= 12'(count_ff);
                  res_st_ff  <= ST_INSERTED;
                  count_ff   <= count_ff + CW'(1);
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  clr_rsp_ff <= 1'b0;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign ready               = (state_ff == S_IDLE);
   assign result.valid        = (state_ff == S_RESP) && out_free;
   assign result.vertex_index = res_idx_ff;
   assign result.status       = res_st_ff;

endmodule

>>> design/spatial_hash_vertex_merge.sv
// a clear sweeps the cell table and then sends its result beat
// an add runs the cell divide, then for each searched cell the hash and modulo,
// the probe steps through the table and a check of each bucket member
// up to 27 cells are searched (only the own cell when the tolerance is zero)
// one item at a time; the core takes new items while a result waits at the output
// reset runs a clearing pass over the cell table, tready low
`timescale 1ns / 1ps
module spatial_hash_vertex_merge #(
   parameter int MAX_VERTICES = 4096,
   parameter int CELL_SLOTS   = 1024,
   parameter int BUCKET_DEPTH = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [30:0]  csr_write_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // coord_x, coord_y, coord_z, vertex_label
   input  logic         req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // vertex_index, zero fill
   output logic [2:0]   rsp_tuser    // status
);
   import shvm_pkg::*;

   logic [30:0] tol_ff;
   logic        out_valid_ff;
   logic [11:0] out_idx_ff;
   logic [2:0]  out_st_ff;
   logic        out_free;
   logic        core_ready;
   item_type    item;
   result_type  result;

   assign item.func         = req_tuser;
   assign item.coord_x      = req_tdata[31:0];
   assign item.coord_y      = req_tdata[63:32];
   assign item.coord_z      = req_tdata[95:64];
   assign item.vertex_label = req_tdata[127:96];

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = core_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   shvm_core #(
      .MAX_VERTICES(MAX_VERTICES),
      .CELL_SLOTS  (CELL_SLOTS),
      .BUCKET_DEPTH(BUCKET_DEPTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (req_tvalid && core_ready),
      .item    (item),
      .tol     (tol_ff),
      .out_free(out_free),
      .ready   (core_ready),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (result.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         out_idx_ff <= result.vertex_index;
         out_st_ff  <= result.status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_idx_ff};
   assign rsp_tuser  = out_st_ff;

endmodule

>>> design/shvm_checker.sv
// port level checks of the vertex merge block and their bind
`timescale 1ns / 1ps
module shvm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [15:0]  rsp_tdata,
   input logic [2:0]   rsp_tuser
);
   import shvm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_MATCHED) || (rsp_tuser == ST_INSERTED)
         || (rsp_tuser == ST_STORE_FULL) || (rsp_tuser == ST_TABLE_FULL)
         || (rsp_tuser == ST_OUT_OF_RANGE))
      else $error("status code out of set");

   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == ST_STORE_FULL) || (rsp_tuser == ST_TABLE_FULL)
         || (rsp_tuser == ST_OUT_OF_RANGE)) |-> rsp_tdata == 16'd0)
      else $error("failed add reports a nonzero index");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while an item is in work");

endmodule

bind spatial_hash_vertex_merge shvm_checker u_shvm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

>>> test/shvm_checker.sv
// checker for the vertex merge block: predicts each result beat and compares it
`timescale 1ns / 1ps
module shvm_scoreboard (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [30:0]  csr_write_data,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [15:0]  rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   output int           pending,
   output int           errors
);
   import shvm_pkg::*;

   localparam int VERTS = 4096;
   localparam int SLOTS = 1024;
   localparam int DEPTH = 8;

   typedef struct {
      logic [11:0] vertex_index;
      logic [2:0]  status;
   } weld_result_type;

   weld_result_type expected_welds[$];

   logic [31:0] tolerance;
   int          rep_x [VERTS];
   int          rep_y [VERTS];
   int          rep_z [VERTS];
   int          rep_count;
   bit          cell_used [SLOTS];
   logic [31:0] cell_label [SLOTS];
   logic [62:0] cell_key [SLOTS];
   int          cell_fill [SLOTS];
   int          cell_member [SLOTS][DEPTH];

   function automatic longint grid_floor(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic logic [62:0] grid_key(longint cx, longint cy, longint cz);
      logic [63:0] ox, oy, oz;
      ox = cx + 1048576;
      oy = cy + 1048576;
      oz = cz + 1048576;
      return {ox[20:0], oy[20:0], oz[20:0]};
   endfunction

   function automatic logic [9:0] grid_hash(logic [31:0] lbl, logic [62:0] key);
      logic [63:0] h;
      h = {1'b0, key} ^ (64'(lbl) * HASH_LABEL_MUL);
      h = h ^ (h >> 29);
      h = h * HASH_MIX_MUL;
      h = h ^ (h >> 32);
      return h[9:0];
   endfunction

   // 1 found, 0 absent with free slot, -1 table full
   function automatic int locate_cell(logic [31:0] lbl, logic [62:0] key,
                                      output int slot);
      int base;
      int s;
      base = grid_hash(lbl, key);
      slot = 0;
      for (int i = 0; i < SLOTS; i++) begin
         s = (base + i) % SLOTS;
         if (!cell_used[s]) begin
            slot = s;
            return 0;
         end
         if (cell_label[s] == lbl && cell_key[s] == key) begin
            slot = s;
            return 1;
         end
      end
      return -1;
   endfunction

   function automatic bit is_close(int m, longint x, longint y, longint z);
      logic [63:0] dx, dy, dz, t;
      longint      ex, ey, ez;
      ex = x - rep_x[m];
      ey = y - rep_y[m];
      ez = z - rep_z[m];
      dx = ex < 0 ? -ex : ex;
      dy = ey < 0 ? -ey : ey;
      dz = ez < 0 ? -ez : ez;
      t = 64'(tolerance);
      if (t == 0) return dx == 0 && dy == 0 && dz == 0;
      if (dx > t || dy > t || dz > t) return 0;
      return dx * dx + dy * dy + dz * dz <= t * t;
   endfunction

   function automatic int scan_cell(logic [31:0] lbl, logic [62:0] key,
                                    longint x, longint y, longint z);
      int s;
      int m;
      if (locate_cell(lbl, key, s) != 1) return -1;
      for (int k = 0; k < cell_fill[s] && k < DEPTH; k++) begin
         m = cell_member[s][k];
         if (m < rep_count && is_close(m, x, y, z)) return m;
      end
      return -1;
   endfunction

   function automatic weld_result_type weld_vertex(logic fn, logic [127:0] d);
      weld_result_type r;
      longint       x, y, z, dv, cx, cy, cz;
      logic [31:0]  lbl;
      logic [62:0]  key;
      int           found;
      int           s;
      int           pr;
      r.vertex_index = '0;
      r.status = ST_MATCHED;
      if (fn == FUNC_CLEAR) begin
         rep_count = 0;
         foreach (cell_used[i]) begin
            cell_used[i] = 0;
            cell_fill[i] = 0;
         end
         return r;
      end
      x = longint'($signed(d[31:0]));
      y = longint'($signed(d[63:32]));
      z = longint'($signed(d[95:64]));
      lbl = d[127:96];
      dv = tolerance == 0 ? 2048 : longint'(tolerance);
      cx = grid_floor(x, dv);
      cy = grid_floor(y, dv);
      cz = grid_floor(z, dv);
      if (tolerance != 0 && (cx < -1048575 || cx > 1048574 || cy < -1048575 ||
            cy > 1048574 || cz < -1048575 || cz > 1048574)) begin
         r.status = ST_OUT_OF_RANGE;
         return r;
      end
      key = grid_key(cx, cy, cz);
      found = scan_cell(lbl, key, x, y, z);
      if (found < 0 && tolerance != 0) begin
         for (int ox = -1; ox <= 1 && found < 0; ox++)
            for (int oy = -1; oy <= 1 && found < 0; oy++)
               for (int oz = -1; oz <= 1 && found < 0; oz++)
                  if (!(ox == 0 && oy == 0 && oz == 0))
                     found = scan_cell(lbl, grid_key(cx + ox, cy + oy, cz + oz), x, y, z);
      end
      if (found >= 0) begin
         r.vertex_index = 12'(found);
         return r;
      end
      if (rep_count >= VERTS) begin
         r.status = ST_STORE_FULL;
         return r;
      end
      pr = locate_cell(lbl, key, s);
      if (pr < 0 || (pr == 1 && cell_fill[s] >= DEPTH)) begin
         r.status = ST_TABLE_FULL;
         return r;
      end
      if (pr == 0) begin
         cell_used[s] = 1;
         cell_label[s] = lbl;
         cell_key[s] = key;
         cell_fill[s] = 0;
      end
      cell_member[s][cell_fill[s]] = rep_count;
      cell_fill[s]++;
      rep_x[rep_count] = int'(x);
      rep_y[rep_count] = int'(y);
      rep_z[rep_count] = int'(z);
      r.vertex_index = 12'(rep_count);
      r.status = ST_INSERTED;
      rep_count++;
      return r;
   endfunction

   assign pending = expected_welds.size();

   always @(posedge clock) begin
      weld_result_type want;
      if (reset) begin
         tolerance = 32'(TOL_RESET);
         rep_count = 0;
         errors = 0;
         foreach (cell_used[i]) begin
            cell_used[i] = 0;
            cell_fill[i] = 0;
         end
         expected_welds.delete();
      end else begin
         if (csr_write_enable) tolerance = {1'b0, csr_write_data};
         if (req_tvalid && req_tready)
            expected_welds.insert(expected_welds.size(), weld_vertex(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_welds.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result beat: index %0d status %0d",
                           rsp_tdata[11:0], rsp_tuser);
            end else begin
               want = expected_welds.pop_front();
               if (want.vertex_index !== rsp_tdata[11:0] || want.status !== rsp_tuser) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected index %0d status %0d, got index %0d status %0d",
                              want.vertex_index, want.status, rsp_tdata[11:0], rsp_tuser);
               end
            end
         end
      end
   end

endmodule

>>> test/tb_top.sv
// testbench top for the vertex merge block: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
   import shvm_pkg::*;

   localparam longint CYCLE_LIMIT = 20000000;

   logic         clock;
   logic         reset;
   logic         csr_write_enable;
   logic [30:0]  csr_write_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // coord_x, coord_y, coord_z, vertex_label
   logic         req_tuser;   // func
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;   // vertex_index, zero fill
   logic [2:0]   rsp_tuser;   // status
   int           pending;
   int           errors;

   int           idle_pct;
   int           stall_pct;
   int           hold_req;
   int           hold_seen;
   int           hold_cycles;
   longint       cycles;
   logic [31:0]  cur_tol;
   int           pool_x [64];
   int           pool_y [64];
   int           pool_z [64];
   logic [31:0]  pool_l [64];
   int           pool_n;

   spatial_hash_vertex_merge dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   shvm_scoreboard u_scoreboard (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .pending(pending), .errors(errors)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver side, long hold-off counted here
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_cycles = 3000;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= stall_pct;
      end
   end

   task automatic send_beat(logic fn, int x, int y, int z, logic [31:0] lbl);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= fn;
      req_tdata <= {lbl, z, y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (fn == FUNC_ADD) begin
         pool_x[pool_n % 64] = x;
         pool_y[pool_n % 64] = y;
         pool_z[pool_n % 64] = z;
         pool_l[pool_n % 64] = lbl;
         pool_n++;
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_tolerance(logic [30:0] t);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= t;
      cur_tol = {1'b0, t};
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [31:0] pick_label();
      case ($urandom_range(0, 5))
         0, 1, 2: return 32'd0;
         3: return 32'd1;
         4: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_beat();
      int kind;
      int j;
      int span;
      int x, y, z;
      logic [31:0] lbl;
      kind = $urandom_range(0, 99);
      span = cur_tol == 0 ? 0 : (cur_tol > 524288 ? 524288 : int'(cur_tol));
      j = pool_n == 0 ? 0 : $urandom_range(0, (pool_n < 64 ? pool_n : 64) - 1);
      if (kind < 2) begin
         send_beat(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 60 && pool_n > 0) begin
         x = pool_x[j] + $urandom_range(0, 2 * span) - span;
         y = pool_y[j] + $urandom_range(0, 2 * span) - span;
         z = pool_z[j] + $urandom_range(0, 2 * span) - span;
         if (cur_tol == 0 && $urandom_range(0, 1)) x = x + 1;
         lbl = kind < 55 ? pool_l[j] : pick_label();
         send_beat(FUNC_ADD, x, y, z, lbl);
      end else if (kind < 88) begin
         send_beat(FUNC_ADD, $urandom_range(0, 1 << 22) - (1 << 21),
                   $urandom_range(0, 1 << 22) - (1 << 21),
                   $urandom_range(0, 1 << 22) - (1 << 21), pick_label());
      end else begin
         send_beat(FUNC_ADD, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic random_block(logic [30:0] t);
      set_tolerance(t);
      send_beat(FUNC_CLEAR, 0, 0, 0, 0);
      for (int m = 0; m < 4; m++) begin
         case (m)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 76; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 76; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         for (int i = 0; i < 45; i++) begin
            if (m == 0 && i == 10) hold_req++;
            if (m == 3 && i == 20) drain();
            random_beat();
         end
      end
   endtask

   initial begin
      reset = 1;
      csr_write_enable = 0;
      csr_write_data = '0;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = FUNC_ADD;
      idle_pct = 0;
      stall_pct = 0;
      hold_req = 0;
      pool_n = 0;
      cur_tol = 32'(TOL_RESET);
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // default tolerance: own cell, neighbor cell, radius edge, labels, extremes
      send_beat(FUNC_ADD, 0, 0, 0, 0);
      send_beat(FUNC_ADD, 0, 0, 0, 0);
      send_beat(FUNC_ADD, 30000, -20000, 10000, 0);
      send_beat(FUNC_ADD, 65536, 0, 0, 0);
      send_beat(FUNC_ADD, 131073, 0, 0, 0);
      send_beat(FUNC_ADD, 65537 + 65536, 0, 0, 0);
      send_beat(FUNC_ADD, 0, 0, 0, 32'hFFFF_FFFF);
      send_beat(FUNC_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678);
      send_beat(FUNC_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678);
      send_beat(FUNC_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678);
      send_beat(FUNC_CLEAR, 0, 0, 0, 0);
      send_beat(FUNC_ADD, 0, 0, 0, 0);

      // tolerance one: cells run out of range at large coordinates
      set_tolerance(31'd1);
      send_beat(FUNC_ADD, 32'h7FFF_FFFF, 0, 0, 0);
      send_beat(FUNC_ADD, 0, 32'h8000_0000, 0, 0);
      send_beat(FUNC_ADD, 5, 5, 5, 0);
      send_beat(FUNC_ADD, 6, 5, 5, 0);

      // exact matching
      set_tolerance(31'd0);
      send_beat(FUNC_ADD, 5, 6, 7, 9);
      send_beat(FUNC_ADD, 5, 6, 7, 9);
      send_beat(FUNC_ADD, 5, 6, 8, 9);

      // one cell over its bucket depth
      send_beat(FUNC_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < 9; i++) send_beat(FUNC_ADD, i, 0, 0, 3);

      random_block(31'd65536);
      random_block(31'd0);
      random_block(31'd1);
      random_block(31'h7FFF_FFFF);
      random_block(31'($urandom_range(4096, 1 << 20)));

      drain();
      repeat (50) @(negedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
